// File: sv/dmxspa_pkg.sv
// Shared field widths, status codes, controller states and control structs of the patch allocator.
package dmxspa_pkg;

  localparam int ID_W       = 16;
  localparam int UNI_W      = 8;
  localparam int ADDR_W     = 16;
  localparam int FOOT_W     = 10;
  localparam int STATUS_W   = 4;
  localparam int CONFLICT_W = 8;

  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 4'd0,
    ST_CAPACITY    = 4'd1,
    ST_DUPLICATE   = 4'd2,
    ST_UNIVERSE    = 4'd3,
    ST_ADDRESS     = 4'd4,
    ST_NO_PROFILE  = 4'd5,
    ST_BAD_PROFILE = 4'd6,
    ST_OVERFLOW    = 4'd7,
    ST_OVERLAP     = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_IDCHK,
    S_DECIDE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_CLAIM,
    S_COMMIT,
    S_WIPE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic set_chk;
    logic scan_start;
    logic scan_step;
    logic claim_wr;
    logic set_overlap;
    logic commit;
    logic clr_step;
    logic set_ok;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic pre_fail;
    logic slot_taken;
    logic cnt_last;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/dmxspa_if.sv
// Request and result channel interfaces of the patch allocator.
interface dmxspa_in_if import dmxspa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ID_W-1:0]   fixture_id;
  logic [UNI_W-1:0]  universe;
  logic [ADDR_W-1:0] start_address;
  logic              has_profile;
  logic              profile_valid;
  logic [FOOT_W-1:0] footprint;

  modport source (output valid, action, fixture_id, universe, start_address, has_profile,
                  profile_valid, footprint, input ready);
  modport sink (input valid, action, fixture_id, universe, start_address, has_profile,
                profile_valid, footprint, output ready);
endinterface

interface dmxspa_out_if import dmxspa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [CONFLICT_W-1:0] conflict_id;

  modport source (output valid, status, conflict_id, input ready);
  modport sink (input valid, status, conflict_id, output ready);
endinterface

// File: sv/dmxspa_ram.sv
// Generic single-port RAM with registered read data.
module dmxspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wr_data;
    end
    rd_data_r <= mem_r[addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/dmxspa_ctrl.sv
// Sequencing state machine of the patch allocator.
module dmxspa_ctrl import dmxspa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:     if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_IDCHK;
      S_IDCHK:    state_nxt = stat.is_clear ? S_WIPE : S_DECIDE;
      S_DECIDE:   state_nxt = stat.pre_fail ? S_RESULT : S_SCAN_RD;
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (stat.slot_taken) begin
          state_nxt = S_RESULT;
        end else if (stat.cnt_last) begin
          state_nxt = S_CLAIM;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_CLAIM:    if (stat.cnt_last) state_nxt = S_COMMIT;
      S_COMMIT:   state_nxt = S_RESULT;
      S_WIPE:     if (stat.clr_last) state_nxt = S_RESULT;
      S_RESULT:   if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_INIT: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_DECIDE: begin
        cmd.set_chk    = stat.pre_fail;
        cmd.scan_start = !stat.pre_fail;
      end
      S_SCAN_CHK: begin
        if (stat.slot_taken) begin
          cmd.set_overlap = 1'b1;
        end else if (stat.cnt_last) begin
          // Rewind to the first slot for the claiming pass.
          cmd.scan_start = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_CLAIM: begin
        cmd.claim_wr  = 1'b1;
        cmd.scan_step = !stat.cnt_last;
      end
      S_COMMIT: cmd.commit = 1'b1;
      S_WIPE: begin
        cmd.clr_step = 1'b1;
        cmd.set_ok   = stat.clr_last;
      end
      S_RESULT: cmd.emit = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: sv/dmxspa_dp.sv
// Datapath of the patch allocator: request registers, check chain, slot and id maps, result register.
module dmxspa_dp import dmxspa_pkg::*; #(
  parameter int MAX_FIXTURES   = 256,
  parameter int NUM_UNIVERSES  = 4,
  parameter int UNIVERSE_SLOTS = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  in_action,
  input  logic [ID_W-1:0]       in_fixture_id,
  input  logic [UNI_W-1:0]      in_universe,
  input  logic [ADDR_W-1:0]     in_start_address,
  input  logic                  in_has_profile,
  input  logic                  in_profile_valid,
  input  logic [FOOT_W-1:0]     in_footprint,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [CONFLICT_W-1:0] out_conflict_id
);

  localparam int SLOT_TOTAL = NUM_UNIVERSES * UNIVERSE_SLOTS;
  localparam int SAW        = $clog2(SLOT_TOTAL);
  localparam int IAW        = $clog2(MAX_FIXTURES);
  localparam int CNTW       = $clog2(MAX_FIXTURES + 1);
  localparam int CNW        = $clog2(UNIVERSE_SLOTS);
  localparam int CLR_DEPTH  = (SLOT_TOTAL > MAX_FIXTURES) ? SLOT_TOTAL : MAX_FIXTURES;
  localparam int CPW        = $clog2(CLR_DEPTH);
  localparam int CPX        = CPW + 1;
  localparam int IXW        = 26;
  localparam int SUMW       = ADDR_W + 1;
  localparam int OW         = IAW + 1;

  // Latched request.
  logic              act_r;
  logic [ID_W-1:0]   id_r;
  logic [UNI_W-1:0]  uni_r;
  logic [ADDR_W-1:0] addr_r;
  logic              hasp_r;
  logic              pv_r;
  logic [FOOT_W-1:0] foot_r;

  logic [SAW-1:0]        ptr_r;
  logic [CNW-1:0]        cnt_r;
  logic [CPW-1:0]        clr_ptr_r, clr_ptr_nxt;
  logic [CNTW-1:0]       count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               res_status_r;
  logic [CONFLICT_W-1:0] res_conflict_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [CONFLICT_W-1:0] out_conflict_r;

  status_t               chk_status;
  logic [CONFLICT_W-1:0] chk_conflict;
  logic [SUMW-1:0]       end_sum;
  logic [IXW-1:0]        start_full;
  logic [SAW-1:0]        start_idx;
  logic                  clr_last;
  logic                  clr_slot_in;
  logic                  clr_id_in;

  logic                       slot_we;
  logic [SAW-1:0]             slot_addr;
  logic [OW-1:0]              slot_wdata;
  logic [OW-1:0]              slot_rdata;
  logic [IAW+CONFLICT_W-1:0]  owner_ext;
  logic                       id_we;
  logic [IAW-1:0]             id_addr;
  logic [0:0]                 id_wdata;
  logic [0:0]                 id_rdata;

  // One past the last slot of the footprint, zero-based; must not pass the universe end.
  assign end_sum    = SUMW'(addr_r) + SUMW'(foot_r) - SUMW'(1);
  assign start_full = IXW'(uni_r) * IXW'(UNIVERSE_SLOTS) + IXW'(addr_r) - IXW'(1);
  assign start_idx  = start_full[SAW-1:0];

  always_comb begin
    chk_status   = ST_OK;
    chk_conflict = '0;
    if (count_r >= CNTW'(MAX_FIXTURES) || id_r >= ID_W'(MAX_FIXTURES)) begin
      chk_status = ST_CAPACITY;
    end else if (id_rdata[0]) begin
      chk_status   = ST_DUPLICATE;
      chk_conflict = id_r[CONFLICT_W-1:0];
    end else if (uni_r >= UNI_W'(NUM_UNIVERSES)) begin
      chk_status = ST_UNIVERSE;
    end else if (addr_r == '0 || addr_r > ADDR_W'(UNIVERSE_SLOTS)) begin
      chk_status = ST_ADDRESS;
    end else if (!hasp_r) begin
      chk_status = ST_NO_PROFILE;
    end else if (!pv_r || foot_r == '0 || foot_r > FOOT_W'(UNIVERSE_SLOTS)) begin
      chk_status = ST_BAD_PROFILE;
    end else if (end_sum > SUMW'(UNIVERSE_SLOTS)) begin
      chk_status = ST_OVERFLOW;
    end
  end

  // The clearing sweep covers whichever map is deeper.
  assign clr_last    = clr_ptr_r == CPW'(CLR_DEPTH - 1);
  assign clr_slot_in = CPX'(clr_ptr_r) < CPX'(SLOT_TOTAL);
  assign clr_id_in   = CPX'(clr_ptr_r) < CPX'(MAX_FIXTURES);

  assign slot_we    = (cmd.clr_step && clr_slot_in) || cmd.claim_wr;
  assign slot_addr  = cmd.clr_step ? clr_ptr_r[SAW-1:0] : ptr_r;
  assign slot_wdata = cmd.clr_step ? '0 : {1'b1, id_r[IAW-1:0]};
  assign owner_ext  = {{CONFLICT_W{1'b0}}, slot_rdata[IAW-1:0]};

  assign id_we    = (cmd.clr_step && clr_id_in) || cmd.commit;
  assign id_addr  = cmd.clr_step ? clr_ptr_r[IAW-1:0] : id_r[IAW-1:0];
  assign id_wdata = cmd.commit;

  dmxspa_ram #(.WIDTH(OW), .DEPTH(SLOT_TOTAL)) u_slot_ram (
    .clk     (clk),
    .we      (slot_we),
    .addr    (slot_addr),
    .wr_data (slot_wdata),
    .rd_data (slot_rdata)
  );

  dmxspa_ram #(.WIDTH(1), .DEPTH(MAX_FIXTURES)) u_id_ram (
    .clk     (clk),
    .we      (id_we),
    .addr    (id_addr),
    .wr_data (id_wdata),
    .rd_data (id_rdata)
  );

  always_comb begin
    clr_ptr_nxt = clr_ptr_r;
    if (cmd.clr_step) begin
      clr_ptr_nxt = clr_last ? '0 : clr_ptr_r + CPW'(1);
    end
    count_nxt = count_r;
    if (cmd.clr_step) begin
      count_nxt = '0;
    end else if (cmd.commit) begin
      count_nxt = count_r + CNTW'(1);
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_ptr_r   <= clr_ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r  <= in_action;
      id_r   <= in_fixture_id;
      uni_r  <= in_universe;
      addr_r <= in_start_address;
      hasp_r <= in_has_profile;
      pv_r   <= in_profile_valid;
      foot_r <= in_footprint;
    end
    if (cmd.scan_start) begin
      ptr_r <= start_idx;
      cnt_r <= CNW'(foot_r - FOOT_W'(1));
    end else if (cmd.scan_step) begin
      ptr_r <= ptr_r + SAW'(1);
      cnt_r <= cnt_r - CNW'(1);
    end
    if (cmd.set_chk) begin
      res_status_r   <= chk_status;
      res_conflict_r <= chk_conflict;
    end else if (cmd.set_overlap) begin
      res_status_r   <= ST_OVERLAP;
      res_conflict_r <= owner_ext[CONFLICT_W-1:0];
    end else if (cmd.commit || cmd.set_ok) begin
      res_status_r   <= ST_OK;
      res_conflict_r <= '0;
    end
    if (cmd.emit) begin
      out_status_r   <= res_status_r;
      out_conflict_r <= res_conflict_r;
    end
  end

  assign stat.is_clear   = act_r == ACT_CLEAR;
  assign stat.pre_fail   = chk_status != ST_OK;
  assign stat.slot_taken = slot_rdata[OW-1];
  assign stat.cnt_last   = cnt_r == '0;
  assign stat.clr_last   = clr_last;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_conflict_id = out_conflict_r;

endmodule

// File: sv/dmx_slot_patch_allocator.sv
// Top level of the DMX slot patch allocator: controller, datapath and checks.
//
//   Channel   Direction  Carries
//   in_chan   sink       action, fixture_id, universe, start_address, has_profile,
//                        profile_valid, footprint
//   out_chan  source     status, conflict_id
//
// One request is in service at a time; the next one is taken once the current
// result has been moved into the output register, which may still be waiting.
// A failed check is latched in S_DECIDE and reported from S_RESULT. An add that
// passes scans its footprint, reading each slot in S_SCAN_RD and checking it in
// S_SCAN_CHK (registered read of the slot RAM), stops at the first taken slot
// and otherwise claims the footprint at one cycle per slot.
// A clear, and the sweep after reset, write one entry of the slot and id maps
// per cycle over max(NUM_UNIVERSES * UNIVERSE_SLOTS, MAX_FIXTURES) entries; no
// request is taken during the reset sweep. A stalled output only holds the
// output register; the controller waits for it before it reports.
module dmx_slot_patch_allocator import dmxspa_pkg::*; #(
  parameter int MAX_FIXTURES   = 256,
  parameter int NUM_UNIVERSES  = 4,
  parameter int UNIVERSE_SLOTS = 512
) (
  input logic           clk,
  input logic           rst_n,
  dmxspa_in_if.sink     in_chan,
  dmxspa_out_if.source  out_chan
);

  // Control and status between the sequencer and the datapath.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     ctrl_ready;

  dmxspa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ctrl_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  assign in_chan.ready = ctrl_ready;

  // The datapath owns both maps, the fixture count and the output register.
  dmxspa_dp #(
    .MAX_FIXTURES   (MAX_FIXTURES),
    .NUM_UNIVERSES  (NUM_UNIVERSES),
    .UNIVERSE_SLOTS (UNIVERSE_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .stat             (dp_stat),
    .in_action        (in_chan.action),
    .in_fixture_id    (in_chan.fixture_id),
    .in_universe      (in_chan.universe),
    .in_start_address (in_chan.start_address),
    .in_has_profile   (in_chan.has_profile),
    .in_profile_valid (in_chan.profile_valid),
    .in_footprint     (in_chan.footprint),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_status       (out_chan.status),
    .out_conflict_id  (out_chan.conflict_id)
  );

  // A request transaction always puts the block out of service for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request taken while the previous one is still in service");

  // A new result only appears while the controller is busy, never from idle.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> !$past(in_chan.ready))
    else $error("result raised without a request in service");

  // Only duplicate and overlap results name a conflicting fixture.
  a_conflict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.status == ST_DUPLICATE || out_chan.status == ST_OVERLAP ||
                        out_chan.conflict_id == '0))
    else $error("conflict id set on a result that has no conflict");

endmodule
